FILE: rtl/core/rls_pkg.sv
// Shared types and constants for the replicated log store.
// No dependencies; every other file of the block imports this package.
package rls_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int IDX_W     = 32;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND   = 3'd0,
    ACT_MATCH    = 3'd1,
    ACT_TRUNCATE = 3'd2,
    ACT_COMPACT  = 3'd3,
    ACT_SET_BASE = 3'd4,
    ACT_STREAM   = 3'd5,
    ACT_TERM_AT  = 3'd6
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_ZERO_INDEX  = 3'd1,
    ST_NOT_CONTIG  = 3'd2,
    ST_FULL        = 3'd3,
    ST_ABSENT      = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic exec;        // carry out the action's first step
    logic app_commit;  // append: contiguity/full check and write
    logic resp_load;   // load the single result into the output register
    logic strm_emit;   // load one streamed entry, fetch the next
  } rls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             app_zero;    // append of index 0
    logic             strm_none;   // stream has nothing to return
    logic             strm_final;  // current stream entry is the last
    logic             out_free;    // output register can take a result
  } rls_stat_t;

endpackage

FILE: rtl/core/rls_if.sv
// Valid/ready channel interfaces for the replicated log store.
// Depends on rls_pkg for field widths.
interface rls_in_if;
  import rls_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] term;
  logic [IDX_W-1:0] payload;

  modport source (output valid, action, index, term, payload, input ready);
  modport sink   (input valid, action, index, term, payload, output ready);
endinterface

interface rls_out_if;
  import rls_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic             matched;
  logic             has_entry;
  logic [IDX_W-1:0] entry_index;
  logic [IDX_W-1:0] entry_term;
  logic [IDX_W-1:0] entry_payload;
  logic [IDX_W-1:0] last_log_index;
  logic             last;

  modport source (output valid, status, matched, has_entry, entry_index, entry_term,
                  entry_payload, last_log_index, last, input ready);
  modport sink   (input valid, status, matched, has_entry, entry_index, entry_term,
                  entry_payload, last_log_index, last, output ready);
endinterface

FILE: rtl/core/rls_datapath.sv
// Datapath of the replicated log store: ring memory, log pointers, item
// and output registers. Depends on rls_pkg; driven by rls_ctrl.
module rls_datapath #(
  parameter int DEPTH = rls_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rls_pkg::rls_cmd_t            cmd,
  output rls_pkg::rls_stat_t           stat,
  input  logic [rls_pkg::ACT_W-1:0]    in_action,
  input  logic [rls_pkg::IDX_W-1:0]    in_index,
  input  logic [rls_pkg::IDX_W-1:0]    in_term,
  input  logic [rls_pkg::IDX_W-1:0]    in_payload,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [rls_pkg::ST_W-1:0]     out_status,
  output logic                         out_matched,
  output logic                         out_has_entry,
  output logic [rls_pkg::IDX_W-1:0]    out_entry_index,
  output logic [rls_pkg::IDX_W-1:0]    out_entry_term,
  output logic [rls_pkg::IDX_W-1:0]    out_entry_payload,
  output logic [rls_pkg::IDX_W-1:0]    out_last_log_index,
  output logic                         out_last
);
  import rls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);   // entry count 0..DEPTH
  localparam int SW = $clog2(DEPTH);       // slot number
  localparam logic [CW:0]   DEPTH_SUM = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // (head + k) mod DEPTH; the sum stays below 2*DEPTH
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                            input logic [CW-1:0] k);
    logic [CW:0] sum;
    sum = {{(CW+1-SW){1'b0}}, head} + {1'b0, k};
    if (sum >= DEPTH_SUM) sum = sum - DEPTH_SUM;
    return sum[SW-1:0];
  endfunction

  // ring storage: {term, payload}
  logic [2*IDX_W-1:0] mem [DEPTH];
  logic [2*IDX_W-1:0] rd_r;

  logic [ACT_W-1:0] action_r;
  logic [IDX_W-1:0] idx_r, term_r, pay_r;
  logic [SW-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  status_t          st_r, st_nxt;
  logic             he_r, he_nxt;
  logic             mchk_r, mchk_nxt;
  logic             out_valid_r;

  logic             have, present, idx_gt_last, contig, full, strm_none, load_out;
  logic [IDX_W-1:0] cnt_ext, last_idx, off, from, from_off;
  logic [CW-1:0]    trunc_cnt, kstart;
  logic [CW:0]      k_inc;
  logic             rd_en, wr_en;
  logic [SW-1:0]    rd_addr, wr_addr;

  always_comb begin
    have        = (count_r != '0);
    cnt_ext     = {{(IDX_W-CW){1'b0}}, count_r};
    last_idx    = have ? (first_r + cnt_ext - IDX_W'(1)) : base_r;
    off         = idx_r - first_r;
    present     = have && (idx_r >= first_r) && (off < cnt_ext) && (idx_r != '0);
    idx_gt_last = (idx_r > last_idx);
    contig      = ({1'b0, idx_r} == ({1'b0, last_idx} + (IDX_W+1)'(1)));
    full        = (count_r == DEPTH_CNT);
    from        = (idx_r == '0) ? IDX_W'(1) : idx_r;
    from_off    = from - first_r;
    strm_none   = !have || (from > last_idx);
    kstart      = (from <= first_r) ? '0 : from_off[CW-1:0];
    k_inc       = {1'b0, k_r} + (CW+1)'(1);
    if (idx_r == '0 || !have)  trunc_cnt = '0;
    else if (idx_gt_last)      trunc_cnt = count_r;
    else if (idx_r <= first_r) trunc_cnt = '0;
    else                       trunc_cnt = off[CW-1:0];
  end

  assign stat.act        = action_r;
  assign stat.app_zero   = (idx_r == '0);
  assign stat.strm_none  = strm_none;
  assign stat.strm_final = (k_inc == {1'b0, count_r});
  assign stat.out_free   = !out_valid_r || out_ready;

  // state updates
  always_comb begin
    head_nxt  = head_r;
    first_nxt = first_r;
    count_nxt = count_r;
    base_nxt  = base_r;
    k_nxt     = k_r;
    st_nxt    = st_r;
    he_nxt    = he_r;
    mchk_nxt  = mchk_r;
    if (cmd.exec) begin
      st_nxt   = ST_OK;
      he_nxt   = 1'b0;
      mchk_nxt = 1'b0;
      case (action_r)
        ACT_APPEND: begin
          if (idx_r == '0) st_nxt = ST_ZERO_INDEX;
          else             count_nxt = trunc_cnt;
        end
        ACT_MATCH:    mchk_nxt = present;
        ACT_TRUNCATE: count_nxt = trunc_cnt;
        ACT_COMPACT: begin
          if (idx_r > base_r) base_nxt = idx_r;
          if (idx_r > IDX_W'(1) && have) begin
            if (idx_gt_last) begin
              count_nxt = '0;
            end else if (idx_r > first_r) begin
              head_nxt  = slot_of(head_r, off[CW-1:0]);
              first_nxt = idx_r;
              count_nxt = count_r - off[CW-1:0];
            end
          end
        end
        ACT_SET_BASE: if (idx_r > base_r) base_nxt = idx_r;
        ACT_STREAM:   k_nxt = kstart;
        ACT_TERM_AT: begin
          he_nxt = present;
          if (idx_r != '0 && !present) st_nxt = ST_ABSENT;
        end
        default: ;
      endcase
    end
    if (cmd.app_commit) begin
      if (!contig)   st_nxt = ST_NOT_CONTIG;
      else if (full) st_nxt = ST_FULL;
      else begin
        if (!have) first_nxt = idx_r;
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.strm_emit) k_nxt = k_inc[CW-1:0];
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_of(head_r, off[CW-1:0]);
    if (cmd.exec) begin
      if (action_r == ACT_MATCH || action_r == ACT_TERM_AT) begin
        rd_en = present;
      end else if (action_r == ACT_STREAM) begin
        rd_en   = !strm_none;
        rd_addr = slot_of(head_r, kstart);
      end
    end else if (cmd.strm_emit) begin
      rd_en   = !stat.strm_final;
      rd_addr = slot_of(head_r, k_inc[CW-1:0]);
    end
    wr_en   = cmd.app_commit && contig && !full;
    wr_addr = slot_of(head_r, count_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {term_r, pay_r};
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      first_r     <= '0;
      count_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      first_r <= first_nxt;
      count_r <= count_nxt;
      base_r  <= base_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign load_out = cmd.resp_load || cmd.strm_emit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      idx_r    <= in_index;
      term_r   <= in_term;
      pay_r    <= in_payload;
    end
    k_r    <= k_nxt;
    st_r   <= st_nxt;
    he_r   <= he_nxt;
    mchk_r <= mchk_nxt;
    if (cmd.resp_load) begin
      out_status         <= st_r;
      out_matched        <= (action_r == ACT_MATCH) &&
                            ((idx_r == '0) ? (term_r == '0)
                                           : (mchk_r && rd_r[2*IDX_W-1:IDX_W] == term_r));
      out_has_entry      <= he_r;
      out_entry_index    <= he_r ? idx_r : '0;
      out_entry_term     <= he_r ? rd_r[2*IDX_W-1:IDX_W] : '0;
      out_entry_payload  <= he_r ? rd_r[IDX_W-1:0] : '0;
      out_last_log_index <= last_idx;
      out_last           <= 1'b1;
    end else if (cmd.strm_emit) begin
      out_status         <= ST_OK;
      out_matched        <= 1'b0;
      out_has_entry      <= 1'b1;
      out_entry_index    <= first_r + {{(IDX_W-CW){1'b0}}, k_r};
      out_entry_term     <= rd_r[2*IDX_W-1:IDX_W];
      out_entry_payload  <= rd_r[IDX_W-1:0];
      out_last_log_index <= last_idx;
      out_last           <= stat.strm_final;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/rls_ctrl.sv
// Sequencer of the replicated log store: walks each item through
// execute, append commit, response or entry streaming. Depends on rls_pkg.
module rls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rls_pkg::rls_stat_t stat,
  output rls_pkg::rls_cmd_t  cmd
);
  import rls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_RESP,
    S_STREAM
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.act == ACT_APPEND && !stat.app_zero)     state_nxt = S_APPEND;
        else if (stat.act == ACT_STREAM && !stat.strm_none) state_nxt = S_STREAM;
        else                                              state_nxt = S_RESP;
      end
      S_APPEND: begin
        cmd.app_commit = 1'b1;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_STREAM: begin
        if (stat.out_free) begin
          cmd.strm_emit = 1'b1;
          if (stat.strm_final) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/replicated_log_store.sv
// Top level of the replicated log store: a log of (term, payload) entries
// kept in a ring memory. Depends on rls_pkg, rls_if, rls_ctrl, rls_datapath.
//
// The block keeps up to DEPTH contiguous log entries, their first index and
// count, and a monotonic base index for the compacted prefix. Each input item
// names one action (append, match, truncate, compact, set base, stream from
// an index, term lookup) and produces one result item, except streaming,
// which produces one result per entry from the given index on, sets last
// on the final one, and gives one result without an entry if there is none.
// Every result carries the last log index after the action. Items go one
// at a time: accepted, executed, result loaded into the output register;
// an append of a nonzero index truncates in execute and is checked and
// written in an append step before its result is loaded. A stream loads
// one entry at a time after execute; the ring memory has one registered
// read port, and the next entry is fetched in the same cycle the current
// one is loaded. A new item is accepted in the cycle after the final result
// of the previous one is loaded, while that result may still wait on the
// output side. Backpressure on the output stalls the block. No clearing
// pass is needed after reset: only slots holding live entries are ever read.
module replicated_log_store #(
  parameter int DEPTH = rls_pkg::DEPTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  rls_in_if.sink          in_ch,
  rls_out_if.source       out_ch
);
  import rls_pkg::*;

  rls_cmd_t  cmd;
  rls_stat_t stat;

  // sequencer
  rls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring memory, pointers and result register
  rls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_ch.action),
    .in_index           (in_ch.index),
    .in_term            (in_ch.term),
    .in_payload         (in_ch.payload),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_matched        (out_ch.matched),
    .out_has_entry      (out_ch.has_entry),
    .out_entry_index    (out_ch.entry_index),
    .out_entry_term     (out_ch.entry_term),
    .out_entry_payload  (out_ch.entry_payload),
    .out_last_log_index (out_ch.last_log_index),
    .out_last           (out_ch.last)
  );

endmodule
